// ===== hdl/tsc_pkg.sv =====
// Shared constants for the Taylor-series sine/cosine pipeline.
package tsc_pkg;

  parameter int TERMS_DEF     = 10;
  parameter int FRAC_BITS_DEF = 16;

  // pi and pi/2 in Q30, rescaled to the working fraction width at elaboration
  parameter logic [63:0] PI_Q30      = 64'd3373259426;
  parameter logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// ===== hdl/taylor_sine_cosine.sv =====
// Top level: pipelined Taylor-series sine with square-root cosine.
//
//   channel | valid / stall          | payload
//   --------+------------------------+-------------------------------------
//   input   | in_valid_i / in_stall_o | angle_i (Q2.F radians, signed)
//   output  | out_valid_o / out_stall_i | sine_value_o, cosine_value_o (Q1.F)
//
// One angle enters per cycle while in_stall_o is low; every stage is a register,
// so the throughput is one beat per clock when out_stall_i is low. An angle passes
// the front stages, the term cells, the back stages and a root cell per root bit.
// Reset clears only the valid bits of the stages; payload is not reset.
// A stall backs up stage by stage, and empty stages keep filling meanwhile.
module taylor_sine_cosine #(
  parameter int TERMS     = tsc_pkg::TERMS_DEF,
  parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [FRAC_BITS+2:0] angle_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [FRAC_BITS+1:0] sine_value_o,
  output logic signed [FRAC_BITS+1:0] cosine_value_o
);

  localparam int ANGLE_W  = FRAC_BITS + 3;
  localparam int OUT_W    = FRAC_BITS + 2;
  localparam int AXW      = FRAC_BITS + 2;
  localparam int TW       = FRAC_BITS + 3;
  localparam int XW       = FRAC_BITS + 4;
  localparam int SW       = FRAC_BITS + 5;
  localparam int AS_W     = FRAC_BITS + 1;
  localparam int N        = FRAC_BITS + 1;
  localparam int RAD_W    = 2 * N;
  localparam int RW       = N + 3;
  localparam int SQ_SIDE  = OUT_W + 1;
  localparam int SQW      = 2 * AXW;
  localparam int SCALE_SH = 30 - FRAC_BITS;

  localparam logic [AXW-1:0] PI_QV = AXW'((tsc_pkg::PI_Q30
                                     + ((64'd1 << SCALE_SH) >> 1)) >> SCALE_SH);
  localparam logic [AXW-1:0] HALF_PI_QV = AXW'((tsc_pkg::HALF_PI_Q30
                                     + ((64'd1 << SCALE_SH) >> 1)) >> SCALE_SH);
  localparam logic [SQW-1:0]   X2_HALF = SQW'(1) << (FRAC_BITS - 1);
  localparam logic [SW-1:0]    ONE_U   = SW'(1) << FRAC_BITS;
  localparam logic [RAD_W-1:0] ONE2    = RAD_W'(1) << (2 * FRAC_BITS);

  // ---------------------------------------------------------------- front
  logic               v_f0_q, v_f1_q, v_f2_q;
  logic               en_f0, en_f1, en_f2;
  logic [ANGLE_W-1:0] absr_q;
  logic               neg_f0_q, neg_f1_q, neg_f2_q;
  logic [AXW-1:0]     ax_f1_q, ax_f2_q;
  logic               cneg_f1_q, cneg_f2_q;
  logic [XW-1:0]      x2_f2_q;
  logic [ANGLE_W-1:0] absr_d;
  logic [SQW-1:0]     x2sq_d;

  // term chain taps, index 0 feeds the first cell
  logic                 tc_vld  [TERMS];
  logic                 tc_rdy  [TERMS];
  logic [XW-1:0]        tc_x2   [TERMS];
  logic [TW-1:0]        tc_tmag [TERMS];
  logic                 tc_tneg [TERMS];
  logic signed [SW-1:0] tc_sum  [TERMS];
  logic [0:0]           tc_cneg [TERMS];

  // ----------------------------------------------------------------- back
  logic                 v_b0_q, v_b1_q, v_b2_q, v_b3_q;
  logic                 en_b0, en_b1, en_b2, en_b3;
  logic signed [SW-1:0] sum_b0_q;
  logic                 cneg_b0_q, cneg_b1_q, cneg_b2_q;
  logic signed [SW-1:0] sum_b0_d, sat_d;
  logic [SW-1:0]        abs_d;
  logic [OUT_W-1:0]     sine_b1_q, sine_b2_q;
  logic [AS_W-1:0]      as_b1_q;
  logic [RAD_W-1:0]     rad_b2_q;
  logic                 rnd_d;
  logic [OUT_W-1:0]     cmag_d;
  logic [OUT_W-1:0]     sine_b3_q, cos_b3_q;

  // root chain taps, index 0 feeds the first cell
  logic               sq_vld  [N+1];
  logic               sq_rdy  [N+1];
  logic [RAD_W-1:0]   sq_rad  [N+1];
  logic [RW-1:0]      sq_rem  [N+1];
  logic [N-1:0]       sq_root [N+1];
  logic [SQ_SIDE-1:0] sq_side [N+1];

  // stage enables: load when empty or when the next stage moves
  assign en_b3 = !v_b3_q || !out_stall_i;
  assign en_b2 = !v_b2_q || sq_rdy[0];
  assign en_b1 = !v_b1_q || en_b2;
  assign en_b0 = !v_b0_q || en_b1;
  assign en_f2 = !v_f2_q || tc_rdy[0];
  assign en_f1 = !v_f1_q || en_f2;
  assign en_f0 = !v_f0_q || en_f1;

  assign in_stall_o = !en_f0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f0_q <= 1'b0;
      v_f1_q <= 1'b0;
      v_f2_q <= 1'b0;
      v_b0_q <= 1'b0;
      v_b1_q <= 1'b0;
      v_b2_q <= 1'b0;
      v_b3_q <= 1'b0;
    end else begin
      if (en_f0) v_f0_q <= in_valid_i;
      if (en_f1) v_f1_q <= v_f0_q;
      if (en_f2) v_f2_q <= v_f1_q;
      if (en_b0) v_b0_q <= tc_vld[TERMS-1];
      if (en_b1) v_b1_q <= v_b0_q;
      if (en_b2) v_b2_q <= v_b1_q;
      if (en_b3) v_b3_q <= sq_vld[N];
    end
  end

  // magnitude of the raw angle; the most negative code maps to 2^(F+2)
  assign absr_d = angle_i[ANGLE_W-1] ? ANGLE_W'(~angle_i + 1'b1) : ANGLE_W'(angle_i);
  assign x2sq_d = SQW'(ax_f1_q) * SQW'(ax_f1_q) + X2_HALF;

  always_ff @(posedge clk_i) begin
    if (en_f0) begin
      absr_q   <= absr_d;
      neg_f0_q <= angle_i[ANGLE_W-1];
    end
    if (en_f1) begin
      // clamp the magnitude to pi; the quadrant test sees the same ordering
      ax_f1_q   <= (absr_q > ANGLE_W'(PI_QV)) ? PI_QV : absr_q[AXW-1:0];
      cneg_f1_q <= absr_q > ANGLE_W'(HALF_PI_QV);
      neg_f1_q  <= neg_f0_q;
    end
    if (en_f2) begin
      x2_f2_q   <= x2sq_d[FRAC_BITS +: XW];
      ax_f2_q   <= ax_f1_q;
      neg_f2_q  <= neg_f1_q;
      cneg_f2_q <= cneg_f1_q;
    end
  end

  assign tc_vld[0]  = v_f2_q;
  assign tc_x2[0]   = x2_f2_q;
  assign tc_tmag[0] = TW'(ax_f2_q);
  assign tc_tneg[0] = neg_f2_q;
  assign tc_sum[0]  = '0;
  assign tc_cneg[0] = cneg_f2_q;
  assign tc_rdy[TERMS-1] = en_b0;

  for (genvar k = 1; k < TERMS; k++) begin : g_term
    tsc_term_cell #(
      .FRAC_BITS (FRAC_BITS),
      .DEN       ((2 * k) * (2 * k + 1)),
      .SIDE_W    (1)
    ) u_term (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (tc_vld[k-1]),
      .rdy_o  (tc_rdy[k-1]),
      .x2_i   (tc_x2[k-1]),
      .tmag_i (tc_tmag[k-1]),
      .tneg_i (tc_tneg[k-1]),
      .sum_i  (tc_sum[k-1]),
      .side_i (tc_cneg[k-1]),
      .vld_o  (tc_vld[k]),
      .rdy_i  (tc_rdy[k]),
      .x2_o   (tc_x2[k]),
      .tmag_o (tc_tmag[k]),
      .tneg_o (tc_tneg[k]),
      .sum_o  (tc_sum[k]),
      .side_o (tc_cneg[k])
    );
  end

  // add the last term, saturate to +-1, take the magnitude for the root
  always_comb begin
    if (tc_tneg[TERMS-1]) begin
      sum_b0_d = tc_sum[TERMS-1] - $signed({2'b00, tc_tmag[TERMS-1]});
    end else begin
      sum_b0_d = tc_sum[TERMS-1] + $signed({2'b00, tc_tmag[TERMS-1]});
    end
    if (sum_b0_q > $signed(ONE_U)) begin
      sat_d = $signed(ONE_U);
    end else if (sum_b0_q < -$signed(ONE_U)) begin
      sat_d = -$signed(ONE_U);
    end else begin
      sat_d = sum_b0_q;
    end
    abs_d = sat_d[SW-1] ? SW'(-sat_d) : SW'(sat_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_b0) begin
      sum_b0_q  <= sum_b0_d;
      cneg_b0_q <= tc_cneg[TERMS-1][0];
    end
    if (en_b1) begin
      sine_b1_q <= sat_d[OUT_W-1:0];
      as_b1_q   <= abs_d[AS_W-1:0];
      cneg_b1_q <= cneg_b0_q;
    end
    if (en_b2) begin
      rad_b2_q  <= ONE2 - RAD_W'(as_b1_q) * RAD_W'(as_b1_q);
      sine_b2_q <= sine_b1_q;
      cneg_b2_q <= cneg_b1_q;
    end
  end

  assign sq_vld[0]  = v_b2_q;
  assign sq_rad[0]  = rad_b2_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {cneg_b2_q, sine_b2_q};
  assign sq_rdy[N]  = en_b3;

  for (genvar j = 0; j < N; j++) begin : g_root
    tsc_sqrt_cell #(
      .ROOT_W (N),
      .SIDE_W (SQ_SIDE)
    ) u_root (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (sq_vld[j]),
      .rdy_o  (sq_rdy[j]),
      .rad_i  (sq_rad[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .side_i (sq_side[j]),
      .vld_o  (sq_vld[j+1]),
      .rdy_i  (sq_rdy[j+1]),
      .rad_o  (sq_rad[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .side_o (sq_side[j+1])
    );
  end

  // round to nearest: bump the root when the remainder exceeds it
  assign rnd_d  = sq_rem[N] > RW'(sq_root[N]);
  assign cmag_d = OUT_W'(sq_root[N]) + OUT_W'(rnd_d);

  always_ff @(posedge clk_i) begin
    if (en_b3) begin
      sine_b3_q <= sq_side[N][OUT_W-1:0];
      cos_b3_q  <= sq_side[N][OUT_W] ? OUT_W'(-cmag_d) : cmag_d;
    end
  end

  assign out_valid_o    = v_b3_q;
  assign sine_value_o   = $signed(sine_b3_q);
  assign cosine_value_o = $signed(cos_b3_q);

  // ----------------------------------------------------------- assertions
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_f0_q)
    else $error("accepted angle beat did not enter the first stage");

  a_sine_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_b1_q |-> as_b1_q <= AS_W'(ONE_U))
    else $error("saturated sine magnitude exceeds one");

  a_root_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld[N] |-> sq_rem[N] <= RW'({sq_root[N], 1'b0}))
    else $error("square root remainder exceeds twice the root");

endmodule

// ===== hdl/tsc_term_cell.sv =====
// One series term: multiply by x^2, round, divide by a constant, accumulate.
module tsc_term_cell #(
  parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF,
  parameter int DEN       = 6,
  parameter int SIDE_W    = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  output logic                      rdy_o,
  input  logic [FRAC_BITS+3:0]      x2_i,
  input  logic [FRAC_BITS+2:0]      tmag_i,
  input  logic                      tneg_i,
  input  logic signed [FRAC_BITS+4:0] sum_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      vld_o,
  input  logic                      rdy_i,
  output logic [FRAC_BITS+3:0]      x2_o,
  output logic [FRAC_BITS+2:0]      tmag_o,
  output logic                      tneg_o,
  output logic signed [FRAC_BITS+4:0] sum_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int TW    = FRAC_BITS + 3;
  localparam int XW    = FRAC_BITS + 4;
  localparam int SW    = FRAC_BITS + 5;
  localparam int PW    = FRAC_BITS + 6;
  localparam int MW    = TW + XW;
  localparam int L     = $clog2(DEN);
  localparam int SHIFT = PW + L;
  localparam int PRW   = SHIFT + TW;
  // ceil(2^SHIFT / DEN): exact floor division for any product below 2^PW
  localparam logic [63:0]   RECIP = ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [MW-1:0] HALF  = MW'(1) << (FRAC_BITS - 1);

  logic                 v1_q, v2_q;
  logic                 en1, en2;
  logic [MW-1:0]        prod_d;
  logic signed [SW-1:0] sum_d;
  logic [PRW-1:0]       quo_d;

  logic [PW-1:0]        p1_q;
  logic [XW-1:0]        x2_1_q;
  logic                 tneg1_q;
  logic signed [SW-1:0] sum1_q;
  logic [SIDE_W-1:0]    side1_q;

  logic [XW-1:0]        x2_2_q;
  logic [TW-1:0]        tmag2_q;
  logic                 tneg2_q;
  logic signed [SW-1:0] sum2_q;
  logic [SIDE_W-1:0]    side2_q;

  assign en2   = !v2_q || rdy_i;
  assign en1   = !v1_q || en2;
  assign rdy_o = en1;

  // fold the incoming term into the running sum alongside the multiply
  always_comb begin
    prod_d = MW'(tmag_i) * MW'(x2_i) + HALF;
    if (tneg_i) begin
      sum_d = sum_i - $signed({2'b00, tmag_i});
    end else begin
      sum_d = sum_i + $signed({2'b00, tmag_i});
    end
  end

  assign quo_d = PRW'(p1_q) * PRW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= vld_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p1_q    <= prod_d[FRAC_BITS +: PW];
      x2_1_q  <= x2_i;
      tneg1_q <= tneg_i;
      sum1_q  <= sum_d;
      side1_q <= side_i;
    end
    if (en2) begin
      tmag2_q <= quo_d[SHIFT +: TW];
      tneg2_q <= !tneg1_q;
      x2_2_q  <= x2_1_q;
      sum2_q  <= sum1_q;
      side2_q <= side1_q;
    end
  end

  assign vld_o  = v2_q;
  assign x2_o   = x2_2_q;
  assign tmag_o = tmag2_q;
  assign tneg_o = tneg2_q;
  assign sum_o  = sum2_q;
  assign side_o = side2_q;

endmodule

// ===== hdl/tsc_sqrt_cell.sv =====
// One restoring square-root step: resolve one root bit per beat.
module tsc_sqrt_cell #(
  parameter int ROOT_W = tsc_pkg::FRAC_BITS_DEF + 1,
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  output logic                  rdy_o,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [ROOT_W+2:0]     rem_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  vld_o,
  input  logic                  rdy_i,
  output logic [2*ROOT_W-1:0]   rad_o,
  output logic [ROOT_W+2:0]     rem_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int RW    = ROOT_W + 3;

  logic              v_q, en, ge;
  logic [RW-1:0]     rem_sh, trial;
  logic [RAD_W-1:0]  rad_q;
  logic [RW-1:0]     rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SIDE_W-1:0] side_q;

  assign en    = !v_q || rdy_i;
  assign rdy_o = en;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_i[RW-3:0], rad_i[RAD_W-1 -: 2]};
  assign trial  = RW'({root_i, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q  <= {rad_i[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_i[ROOT_W-2:0], ge};
      side_q <= side_i;
    end
  end

  assign vld_o  = v_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

// ===== dv/tsc_checker.sv =====
// Checker: predicts sine and cosine for every accepted angle and compares result beats.
module tsc_checker #(
  parameter int TERMS     = tsc_pkg::TERMS_DEF,
  parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic signed [FRAC_BITS+2:0] angle_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic signed [FRAC_BITS+1:0] sine_value_i,
  input  logic signed [FRAC_BITS+1:0] cosine_value_i,
  output int                          pending_o,
  output int                          errors_o,
  output int                          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = FRAC_BITS + 3;
  localparam int OW = FRAC_BITS + 2;
  localparam int SH = 30 - FRAC_BITS;
  localparam longint PI_FX   = longint'((tsc_pkg::PI_Q30 + (64'd1 << (SH - 1))) >> SH);
  localparam longint HPI_FX  = longint'((tsc_pkg::HALF_PI_Q30 + (64'd1 << (SH - 1))) >> SH);
  localparam longint ONE_FX  = longint'(1) << FRAC_BITS;

  typedef struct {
    logic signed [AW-1:0] angle;
    logic signed [OW-1:0] sine;
    logic signed [OW-1:0] cosine;
  } trig_t;

  trig_t trig_q[$];

  // (a*b) rounded half up to FRAC_BITS fraction bits, full-width product
  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (FRAC_BITS - 1));
    return 64'(p >> FRAC_BITS);
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] rem, root, b;
    rem  = v;
    root = '0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic trig_t sine_cosine_of(logic signed [AW-1:0] ang);
    trig_t       res;
    longint      x, sum, cosv;
    logic [63:0] ax, x2, tmag, den, mag, rest, c;
    bit          tneg;
    x = ang;
    if (x > PI_FX) x = PI_FX;
    if (x < -PI_FX) x = -PI_FX;
    ax   = (x < 0) ? 64'(-x) : 64'(x);
    x2   = mul_round(ax, ax);
    tmag = ax;
    tneg = (x < 0);
    sum  = x;
    for (int n = 1; n < TERMS; n++) begin
      den  = 64'((2 * n) * (2 * n + 1));
      tmag = mul_round(tmag, x2) / den;
      tneg = !tneg;
      sum  = tneg ? sum - longint'(tmag) : sum + longint'(tmag);
    end
    if (sum > ONE_FX) sum = ONE_FX;
    if (sum < -ONE_FX) sum = -ONE_FX;
    mag  = (sum < 0) ? 64'(-sum) : 64'(sum);
    rest = (64'd1 << (2 * FRAC_BITS)) - mag * mag;
    c    = floor_root(rest);
    // round to nearest; a tie on the remainder rounds down
    if (rest - c * c > c) c = c + 1;
    cosv = longint'(c);
    if (longint'(ax) > HPI_FX) cosv = -cosv;
    res.angle  = ang;
    res.sine   = OW'(sum);
    res.cosine = OW'(cosv);
    return res;
  endfunction

  always @(posedge clk_i) begin
    trig_t want;
    if (!rst_ni) begin
      errors_o  = 0;
      checked_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) trig_q.push_back(sine_cosine_of(angle_i));
      if (out_valid_i && !out_stall_i) begin
        if (trig_q.size() == 0) begin
          $error("unexpected result beat: sine_value %0d cosine_value %0d",
                 sine_value_i, cosine_value_i);
          errors_o++;
        end else begin
          want = trig_q.pop_front();
          checked_o++;
          if (sine_value_i !== want.sine) begin
            $error("sine_value (angle %0d): expected %0d, actual %0d",
                   want.angle, want.sine, sine_value_i);
            errors_o++;
          end
          if (cosine_value_i !== want.cosine) begin
            $error("cosine_value (angle %0d): expected %0d, actual %0d",
                   want.angle, want.cosine, cosine_value_i);
            errors_o++;
          end
        end
      end
    end
    pending_o = trig_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives angles and output back-pressure, and reports the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF;
  localparam int AW = FRAC_BITS + 3;
  localparam int SH = 30 - FRAC_BITS;
  localparam int PI_FX  = int'((tsc_pkg::PI_Q30 + (64'd1 << (SH - 1))) >> SH);
  localparam int HPI_FX = int'((tsc_pkg::HALF_PI_Q30 + (64'd1 << (SH - 1))) >> SH);
  localparam int AMAX = (1 << (AW - 1)) - 1;
  localparam int AMIN = -(1 << (AW - 1));
  localparam int LONG_HOLD = 300;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [AW-1:0]        angle_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [FRAC_BITS+1:0] sine_value_o;
  logic signed [FRAC_BITS+1:0] cosine_value_o;

  int pending, errors, checked;
  int sent_angles;
  bit hold_req;
  bit quiet;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  taylor_sine_cosine uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .angle_i        (angle_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sine_value_o   (sine_value_o),
    .cosine_value_o (cosine_value_o)
  );

  tsc_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .angle_i        (angle_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sine_value_i   (sine_value_o),
    .cosine_value_i (cosine_value_o),
    .pending_o      (pending),
    .errors_o       (errors),
    .checked_o      (checked)
  );

  // Offer one angle and hold it until the beat is taken; called at a rising edge.
  task automatic send_angle(int a);
    in_valid_i <= 1'b1;
    angle_i    <= AW'(a);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_angles++;
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic int random_angle();
    int    pick;
    int    base;
    int    pts[5];
    pick = $urandom_range(0, 99);
    pts  = '{0, HPI_FX, -HPI_FX, PI_FX, -PI_FX};
    if (pick < 70) return int'($urandom_range(0, 2 * PI_FX)) - PI_FX;
    if (pick < 85) begin
      base = pts[$urandom_range(0, 4)];
      return base + int'($urandom_range(0, 16)) - 8;
    end
    // raw 19-bit noise, often beyond +-pi and clamped
    return int'($urandom_range(0, (1 << AW) - 1)) + AMIN;
  endfunction

  // output back-pressure
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk_i);
            out_stall_i <= 1'b0;
          end
          3: begin
            out_stall_i <= 1'b0;
            repeat ($urandom_range(20, 80)) @(posedge clk_i);
          end
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", pending);
    $display("[taylor_sine_cosine] ERROR");
    $finish;
  end

  initial begin
    int directed[$];
    sent_angles = 0;
    hold_req    = 1'b0;
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    angle_i     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, quadrant boundaries, clamping and bit patterns
    directed = '{0, 1, -1, 2, -2, HPI_FX, -HPI_FX, HPI_FX + 1, -HPI_FX - 1,
                 HPI_FX - 1, -HPI_FX + 1, PI_FX, -PI_FX, PI_FX - 1, -PI_FX + 1,
                 PI_FX + 1, -PI_FX - 1, AMAX, AMIN, 'h2AAAA, 'h15555 - (1 << AW),
                 HPI_FX / 2, -HPI_FX / 2};
    foreach (directed[i]) begin
      send_angle(directed[i]);
      maybe_gap();
    end

    repeat (600) begin
      send_angle(random_angle());
      maybe_gap();
    end

    // fill the pipe against a long output hold-off
    hold_req = 1'b1;
    repeat (200) send_angle(random_angle());

    // drain completely before carrying on
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    repeat (800) begin
      send_angle(random_angle());
      maybe_gap();
    end

    // closing stretch at full rate on both sides
    quiet = 1'b1;
    repeat (150) send_angle(random_angle());
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Covered %0d angles: boundaries, clamping, random sweep, noise, back-pressure.",
             sent_angles);
    $display("%0d result beats compared, %0d mismatches.", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("[taylor_sine_cosine] OK");
    end else begin
      $display("[taylor_sine_cosine] ERROR");
    end
    $finish;
  end

endmodule
